>>> rtl/cref_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cref_pkg
// shared types and constants for the clipped rectangle fill engine
// ---------------------------------------------------------------------------
package cref_pkg;

  localparam int FB_WIDTH    = 640;
  localparam int FB_HEIGHT   = 480;

  localparam int COORD_W     = 16;
  localparam int COLOR_W     = 8;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 9;
  localparam int OFF_W       = 19;
  localparam int CLIP_W      = 18;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef struct packed {
    logic               is_load;
    logic               job_ok;
    logic [COL_W-1:0]   col_first;
    logic [COL_W-1:0]   col_last;
    logic [ROW_W-1:0]   row_first;
    logic [ROW_W-1:0]   row_last;
    logic [COLOR_W-1:0] color;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/clipped_rectangle_fill_engine_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clipped_rectangle_fill_engine_top
// clips rectangles to the framebuffer and streams one pixel write per tick
//
// channel  direction  fields
// in_      input      mode, rect_x, rect_y, rect_w, rect_h, fill_color
// out_     output     pixel_offset, pixel_color, last_pixel
//
// one item per cycle unless stalled; a tick's write is queued, then registered
// front clips loads combinationally, back computes the row base multiply on load
// a two-entry command queue lets front and back stall independently
// reset clears the queue, busy and output valid; no clearing pass
// ---------------------------------------------------------------------------
module clipped_rectangle_fill_engine_top #(
  parameter int WIDTH  = cref_pkg::FB_WIDTH,
  parameter int HEIGHT = cref_pkg::FB_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_x,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_y,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_w,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_h,
  input  logic        [cref_pkg::COLOR_W-1:0] in_fill_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [cref_pkg::OFF_W-1:0]   out_pixel_offset,
  output logic        [cref_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                                out_last_pixel
);
  import cref_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_ready;

  cref_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .in_mode       (in_mode),
    .in_rect_x     (in_rect_x),
    .in_rect_y     (in_rect_y),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_fill_color (in_fill_color),
    .cmd           (front_cmd)
  );

  cref_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_cmd    (head_cmd)
  );

  cref_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (head_valid),
    .cmd_ready        (head_ready),
    .cmd              (head_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_offset (out_pixel_offset),
    .out_pixel_color  (out_pixel_color),
    .out_last_pixel   (out_last_pixel)
  );

endmodule
`default_nettype wire

>>> rtl/cref_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cref_front
// classifies input items and clips load rectangles to the framebuffer
// ---------------------------------------------------------------------------
module cref_front #(
  parameter int WIDTH  = cref_pkg::FB_WIDTH,
  parameter int HEIGHT = cref_pkg::FB_HEIGHT
) (
  input  logic                                in_mode,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_x,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_y,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_w,
  input  logic signed [cref_pkg::COORD_W-1:0] in_rect_h,
  input  logic        [cref_pkg::COLOR_W-1:0] in_fill_color,
  output cref_pkg::cmd_t                      cmd
);
  import cref_pkg::*;

  localparam int EXT_W = CLIP_W - COORD_W;
  localparam logic signed [CLIP_W-1:0] W_S   = CLIP_W'(WIDTH);
  localparam logic signed [CLIP_W-1:0] H_S   = CLIP_W'(HEIGHT);
  localparam logic signed [CLIP_W-1:0] ONE_S = CLIP_W'(1);

  logic signed [CLIP_W-1:0] x0, y0, w0, h0;
  logic signed [CLIP_W-1:0] x1, y1, w1, h1;
  logic signed [CLIP_W-1:0] w2, h2;
  logic signed [CLIP_W-1:0] x_end, y_end;
  logic signed [CLIP_W-1:0] col_end, row_end;
  logic                     off_edge;
  logic                     w_pos, h_pos;

  always_comb begin
    x0 = {{EXT_W{in_rect_x[COORD_W-1]}}, in_rect_x};
    y0 = {{EXT_W{in_rect_y[COORD_W-1]}}, in_rect_y};
    w0 = {{EXT_W{in_rect_w[COORD_W-1]}}, in_rect_w};
    h0 = {{EXT_W{in_rect_h[COORD_W-1]}}, in_rect_h};

    off_edge = (x0 >= W_S) || (y0 >= H_S);

    if (x0[CLIP_W-1]) begin
      w1 = w0 + x0;
      x1 = '0;
    end else begin
      w1 = w0;
      x1 = x0;
    end
    if (y0[CLIP_W-1]) begin
      h1 = h0 + y0;
      y1 = '0;
    end else begin
      h1 = h0;
      y1 = y0;
    end

    x_end = x1 + w1;
    y_end = y1 + h1;
    w2 = (x_end > W_S) ? (W_S - x1) : w1;
    h2 = (y_end > H_S) ? (H_S - y1) : h1;

    col_end = x1 + w2 - ONE_S;
    row_end = y1 + h2 - ONE_S;

    w_pos = !w2[CLIP_W-1] && (w2 != '0);
    h_pos = !h2[CLIP_W-1] && (h2 != '0);

    cmd.is_load   = (in_mode == MODE_LOAD);
    cmd.job_ok    = !off_edge && w_pos && h_pos;
    cmd.col_first = x1[COL_W-1:0];
    cmd.col_last  = col_end[COL_W-1:0];
    cmd.row_first = y1[ROW_W-1:0];
    cmd.row_last  = row_end[ROW_W-1:0];
    cmd.color     = in_fill_color;
  end

endmodule
`default_nettype wire

>>> rtl/cref_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cref_queue
// short command queue between the front and back parts
// ---------------------------------------------------------------------------
module cref_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cref_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cref_pkg::cmd_t pop_cmd
);
  import cref_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_MAX);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

>>> rtl/cref_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cref_back
// holds the active fill job and steps one pixel write per tick
// ---------------------------------------------------------------------------
module cref_back #(
  parameter int WIDTH = cref_pkg::FB_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  cref_pkg::cmd_t                cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cref_pkg::OFF_W-1:0]    out_pixel_offset,
  output logic [cref_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_last_pixel
);
  import cref_pkg::*;

  localparam logic [OFF_W-1:0] WIDTH_OFF = OFF_W'(WIDTH);

  logic               busy_r, busy_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   col_first_r, col_first_nxt;
  logic [COL_W-1:0]   col_last_r, col_last_nxt;
  logic [ROW_W-1:0]   row_last_r, row_last_nxt;
  logic [OFF_W-1:0]   row_base_r, row_base_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]   out_offset_r, out_offset_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic               out_last_r, out_last_nxt;

  logic slot_free, take, emit, end_col, end_row;

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = cmd.is_load || !busy_r || slot_free;
  assign take      = cmd_valid && cmd_ready;
  assign emit      = take && !cmd.is_load && busy_r;
  assign end_col   = (cur_col_r == col_last_r);
  assign end_row   = (cur_row_r == row_last_r);

  always_comb begin
    busy_nxt      = busy_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    col_first_nxt = col_first_r;
    col_last_nxt  = col_last_r;
    row_last_nxt  = row_last_r;
    row_base_nxt  = row_base_r;
    color_nxt     = color_r;
    if (take && cmd.is_load) begin
      busy_nxt      = cmd.job_ok;
      cur_col_nxt   = cmd.col_first;
      cur_row_nxt   = cmd.row_first;
      col_first_nxt = cmd.col_first;
      col_last_nxt  = cmd.col_last;
      row_last_nxt  = cmd.row_last;
      row_base_nxt  = OFF_W'(OFF_W'(cmd.row_first) * WIDTH_OFF);
      color_nxt     = cmd.color;
    end else if (emit) begin
      if (end_col) begin
        if (end_row) begin
          busy_nxt = 1'b0;
        end else begin
          cur_row_nxt  = cur_row_r + ROW_W'(1);
          row_base_nxt = row_base_r + WIDTH_OFF;
          cur_col_nxt  = col_first_r;
        end
      end else begin
        cur_col_nxt = cur_col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_offset_nxt = out_offset_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_offset_nxt = row_base_r + OFF_W'(cur_col_r);
      out_color_nxt  = color_r;
      out_last_nxt   = end_col && end_row;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_col_r    <= cur_col_nxt;
    cur_row_r    <= cur_row_nxt;
    col_first_r  <= col_first_nxt;
    col_last_r   <= col_last_nxt;
    row_last_r   <= row_last_nxt;
    row_base_r   <= row_base_nxt;
    color_r      <= color_nxt;
    out_offset_r <= out_offset_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_offset = out_offset_r;
  assign out_pixel_color  = out_color_r;
  assign out_last_pixel   = out_last_r;

`ifndef SYNTH
  a_cursor_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_col_r <= col_last_r) && (cur_row_r <= row_last_r))
    else $error("cursor outside job box");

  a_row_base_match: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (row_base_r == OFF_W'(OFF_W'(cur_row_r) * WIDTH_OFF)))
    else $error("row base out of step with row");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && end_col && end_row) |=> (out_last_r && !busy_r))
    else $error("final pixel did not close job");
`endif

endmodule
`default_nettype wire

>>> dv/clipped_rectangle_fill_engine_top_tb.sv
// ---------------------------------------------------------------------------
// clipped_rectangle_fill_engine_top_tb
// drives rectangle loads and ticks into the fill engine and checks every
// pixel write against a clipping and raster-scan predictor kept in step with
// each input transfer; both sides idle and stall at random, with a long calm
// stretch and pauses that let all pending writes drain
// ---------------------------------------------------------------------------
module clipped_rectangle_fill_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cref_pkg::*;

  localparam int RAND_ITEMS  = 1650;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYC  = 20;

  typedef struct {
    logic                      hold;
    mode_t                     mode;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
    logic [COLOR_W-1:0]        color;
  } fill_req_t;

  typedef struct {
    logic [OFF_W-1:0]   offset;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_mode = MODE_LOAD;
  logic signed [COORD_W-1:0] in_rect_x = '0;
  logic signed [COORD_W-1:0] in_rect_y = '0;
  logic signed [COORD_W-1:0] in_rect_w = '0;
  logic signed [COORD_W-1:0] in_rect_h = '0;
  logic [COLOR_W-1:0]        in_fill_color = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [OFF_W-1:0]          out_pixel_offset;
  logic [COLOR_W-1:0]        out_pixel_color;
  logic                      out_last_pixel;

  fill_req_t req_q[$];
  pixel_t    pixel_q[$];
  int        gen_cnt = 0;
  int        n_in = 0;
  int        outstanding = 0;
  int        errors = 0;
  int        idle_cyc = 0;
  logic      draining = 1'b0;
  logic      calm;

  // predicted engine state
  logic               job_busy = 1'b0;
  logic [COL_W-1:0]   job_col = '0;
  logic [ROW_W-1:0]   job_row = '0;
  logic [COL_W-1:0]   job_col_first = '0;
  logic [COL_W-1:0]   job_col_last = '0;
  logic [ROW_W-1:0]   job_row_last = '0;
  logic [OFF_W-1:0]   job_row_base = '0;
  logic [COLOR_W-1:0] job_color = '0;

  clipped_rectangle_fill_engine_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_w        (in_rect_w),
    .in_rect_h        (in_rect_h),
    .in_fill_color    (in_fill_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_offset (out_pixel_offset),
    .out_pixel_color  (out_pixel_color),
    .out_last_pixel   (out_last_pixel)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  assign calm = (n_in >= 700) && (n_in < 1000);

  task automatic clip_load(input logic signed [COORD_W-1:0] rx, ry, rw, rh,
                           input logic [COLOR_W-1:0] c);
    int x, y, w, h;
    x = rx;
    y = ry;
    w = rw;
    h = rh;
    job_busy = 1'b0;
    if (x >= FB_WIDTH || y >= FB_HEIGHT) return;
    if (x < 0) begin
      w = w + x;
      x = 0;
    end
    if (y < 0) begin
      h = h + y;
      y = 0;
    end
    if (x + w > FB_WIDTH) w = FB_WIDTH - x;
    if (y + h > FB_HEIGHT) h = FB_HEIGHT - y;
    if (w <= 0 || h <= 0) return;
    job_col_first = COL_W'(x);
    job_col_last  = COL_W'(x + w - 1);
    job_row_last  = ROW_W'(y + h - 1);
    job_col       = COL_W'(x);
    job_row       = ROW_W'(y);
    job_row_base  = OFF_W'(y * FB_WIDTH);
    job_color     = c;
    job_busy      = 1'b1;
  endtask

  function automatic pixel_t emit_pixel();
    pixel_t p;
    logic   end_col;
    logic   end_row;
    end_col  = (job_col == job_col_last);
    end_row  = (job_row == job_row_last);
    p.offset = job_row_base + OFF_W'(job_col);
    p.color  = job_color;
    p.last   = end_col && end_row;
    if (end_col) begin
      if (end_row) begin
        job_busy = 1'b0;
      end else begin
        job_row      = job_row + 1'b1;
        job_row_base = job_row_base + OFF_W'(FB_WIDTH);
        job_col      = job_col_first;
      end
    end else begin
      job_col = job_col + 1'b1;
    end
    return p;
  endfunction

  task automatic queue_rect(input int x, y, w, h, input int c);
    fill_req_t r;
    r.hold  = 1'b0;
    r.mode  = MODE_LOAD;
    r.x     = COORD_W'(x);
    r.y     = COORD_W'(y);
    r.w     = COORD_W'(w);
    r.h     = COORD_W'(h);
    r.color = COLOR_W'(c);
    req_q.push_back(r);
    gen_cnt++;
  endtask

  task automatic queue_ticks(input int n);
    fill_req_t r;
    repeat (n) begin
      r.hold  = 1'b0;
      r.mode  = MODE_TICK;
      r.x     = COORD_W'($urandom);
      r.y     = COORD_W'($urandom);
      r.w     = COORD_W'($urandom);
      r.h     = COORD_W'($urandom);
      r.color = COLOR_W'($urandom);
      req_q.push_back(r);
      gen_cnt++;
    end
  endtask

  task automatic queue_hold();
    fill_req_t r;
    r.hold  = 1'b1;
    r.mode  = MODE_LOAD;
    r.x     = '0;
    r.y     = '0;
    r.w     = '0;
    r.h     = '0;
    r.color = '0;
    req_q.push_back(r);
  endtask

  task automatic queue_rect_run(input int x, y, w, h);
    int n;
    n = w * h;
    if (n > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
    else if (n > 0) n = n + $urandom_range(0, 2);
    else n = $urandom_range(0, 2);
    queue_rect(x, y, w, h, $urandom_range(0, 255));
    queue_ticks(n);
  endtask

  // driver
  always @(posedge clk) begin : drive
    fill_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      draining <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (draining) begin
        if (outstanding == 0) draining <= 1'b0;
        in_valid <= 1'b0;
      end else if (req_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 14) begin
        in_valid <= 1'b0;
      end else begin
        r = req_q.pop_front();
        if (r.hold) begin
          draining <= 1'b1;
          in_valid <= 1'b0;
        end else begin
          in_valid      <= 1'b1;
          in_mode       <= r.mode;
          in_rect_x     <= r.x;
          in_rect_y     <= r.y;
          in_rect_w     <= r.w;
          in_rect_h     <= r.h;
          in_fill_color <= r.color;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 14);
  end

  // monitor and predictor
  always @(posedge clk) begin : monitor
    pixel_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected write: offset %0d color %0d last %0b",
                 out_pixel_offset, out_pixel_color, out_last_pixel);
          errors++;
        end else begin
          e = pixel_q.pop_front();
          if (out_pixel_offset !== e.offset) begin
            $error("pixel_offset: expected %0d, got %0d", e.offset, out_pixel_offset);
            errors++;
          end
          if (out_pixel_color !== e.color) begin
            $error("pixel_color: expected %0d, got %0d", e.color, out_pixel_color);
            errors++;
          end
          if (out_last_pixel !== e.last) begin
            $error("last_pixel: expected %0b, got %0b", e.last, out_last_pixel);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        n_in <= n_in + 1;
        if (in_mode == MODE_LOAD)
          clip_load(in_rect_x, in_rect_y, in_rect_w, in_rect_h, in_fill_color);
        else if (job_busy)
          pixel_q.push_back(emit_pixel());
      end
      outstanding <= pixel_q.size();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= STALL_LIMIT) begin
      $display("clipped_rectangle_fill_engine_top_tb: done, errors");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin : stimulus
    int kind, x, y, w, h, limit;

    // tick with no job
    queue_ticks(1);
    // screen clear replaced by the next load
    queue_rect(0, 0, FB_WIDTH, FB_HEIGHT, 8'hA5);
    queue_ticks(3);
    // extent past right and bottom edges
    queue_rect(FB_WIDTH - 2, FB_HEIGHT - 2, 10, 10, 8'hFF);
    queue_ticks(5);
    // negative start on both axes
    queue_rect(-5, -3, 7, 5, 8'h00);
    queue_ticks(4);
    queue_hold();
    // off-screen starts and empty rectangles
    queue_rect(FB_WIDTH, 0, 5, 5, 8'h11);
    queue_rect(0, FB_HEIGHT, 5, 5, 8'h22);
    queue_rect(-32768, -32768, 32767, 32767, 8'h33);
    queue_rect(32767, 32767, -32768, -32768, 8'h44);
    queue_ticks(1);
    // last pixel of the screen
    queue_rect(FB_WIDTH - 1, FB_HEIGHT - 1, 1, 1, 8'h5A);
    queue_ticks(2);
    // empty load drops a job in progress
    queue_rect(3, 2, 2, 2, 8'hC3);
    queue_ticks(2);
    queue_rect(0, 0, 0, 1, 8'h77);
    queue_ticks(1);

    limit = gen_cnt + RAND_ITEMS;
    while (gen_cnt < limit) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        x = $urandom_range(0, FB_WIDTH + 7) - 4;
        y = $urandom_range(0, FB_HEIGHT + 7) - 4;
        queue_rect_run(x, y, $urandom_range(1, 8), $urandom_range(1, 4));
      end else if (kind < 70) begin
        x = FB_WIDTH - $urandom_range(1, 6);
        y = FB_HEIGHT - $urandom_range(1, 4);
        queue_rect_run(x, y, $urandom_range(1, 10), $urandom_range(1, 6));
      end else if (kind < 76) begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 8);
        queue_rect_run(-$urandom_range(1, 20), -$urandom_range(0, 6), w, h);
      end else if (kind < 84) begin
        queue_rect($urandom, $urandom, $urandom, $urandom, $urandom);
        queue_ticks($urandom_range(0, 3));
      end else if (kind < 90) begin
        queue_ticks($urandom_range(1, 3));
      end else if (kind < 95) begin
        x = $urandom_range(0, FB_WIDTH - 1);
        y = $urandom_range(0, FB_HEIGHT - 1);
        w = $urandom_range(0, 1) ? -$urandom_range(0, 40000) : $urandom_range(1, 6);
        h = (w > 0) ? -$urandom_range(0, 40000) : $urandom_range(1, 6);
        queue_rect(x, y, w, h, $urandom_range(0, 255));
        queue_ticks($urandom_range(0, 2));
      end else if (kind < 97) begin
        queue_rect_run($urandom_range(0, FB_WIDTH - 1), $urandom_range(0, FB_HEIGHT - 1),
                       $urandom_range(20, 90), 1);
      end else begin
        queue_hold();
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || draining || outstanding != 0);
    repeat (SETTLE_CYC) @(negedge clk);

    if (errors == 0 && pixel_q.size() == 0) begin
      $display("clipped_rectangle_fill_engine_top_tb: done, clean");
    end else begin
      $display("clipped_rectangle_fill_engine_top_tb: done, errors");
    end
    $finish;
  end

endmodule
